// ----- src/ttpe_pkg.sv -----
`default_nettype none
package ttpe_pkg;

	localparam int TEMP_BITS_DEF   = 18;
	localparam int CFG_IDX_BITS    = 3;
	localparam int SENSOR_BITS     = 8;
	localparam int SENSOR_SEL_BITS = 9;
	localparam int STATE_BITS      = 8;
	localparam int COUNT_BITS      = 8;
	localparam logic [SENSOR_SEL_BITS-1:0] ANY_SENSOR = 9'd256;

	typedef enum logic [2:0] {
		KIND_INVALID  = 3'd0,
		KIND_CRITICAL = 3'd1,
		KIND_HOT      = 3'd2,
		KIND_POLLING  = 3'd3,
		KIND_ACTIVE   = 3'd4,
		KIND_PASSIVE  = 3'd5,
		KIND_MAX      = 3'd6
	} trip_kind_t;

	typedef enum logic [2:0] {
		REL_NONE = 3'd0,
		REL_EQ   = 3'd1,
		REL_GT   = 3'd2,
		REL_LT   = 3'd3,
		REL_LE   = 3'd4,
		REL_GE   = 3'd5
	} dep_rel_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TRIP_KIND     = 3'd0,
		REG_TRIP_TEMP     = 3'd1,
		REG_HYSTERESIS    = 3'd2,
		REG_SENSOR_SELECT = 3'd3,
		REG_DEP_RELATION  = 3'd4,
		REG_DEP_VALUE     = 3'd5,
		REG_CRIT_LIMIT    = 3'd6,
		REG_IGNORE_CRIT   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PREF_OFF    = 2'd0,
		PREF_PERF   = 2'd1,
		PREF_ENERGY = 2'd2,
		PREF_OTHER  = 2'd3
	} pref_t;

	typedef enum logic [1:0] {
		COOL_NONE = 2'd0,
		COOL_ON   = 2'd1,
		COOL_OFF  = 2'd2
	} cool_action_t;

	typedef enum logic [1:0] {
		POLL_NONE  = 2'd0,
		POLL_START = 2'd1,
		POLL_STOP  = 2'd2
	} poll_event_t;

endpackage
`default_nettype wire

// ----- src/ttpe_in_if.sv -----
`default_nettype none
interface ttpe_in_if
	import ttpe_pkg::*;
#(
	parameter int TEMP_BITS = TEMP_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SENSOR_BITS-1:0] reading_sensor;
	logic [TEMP_BITS-1:0]   reading_temp;
	logic [1:0]             preference;
	logic [STATE_BITS-1:0]  cooling_state;

	modport source (output valid, output reading_sensor, output reading_temp,
		output preference, output cooling_state, input ready);
	modport sink (input valid, input reading_sensor, input reading_temp,
		input preference, input cooling_state, output ready);
endinterface
`default_nettype wire

// ----- src/ttpe_out_if.sv -----
`default_nettype none
interface ttpe_out_if;
	logic       valid;
	logic       ready;
	logic       applicable;
	logic [1:0] cool_action;
	logic       shutdown_req;
	logic       suspend_req;
	logic [1:0] poll_event;
	logic       reset_flag;

	modport source (output valid, output applicable, output cool_action,
		output shutdown_req, output suspend_req, output poll_event,
		output reset_flag, input ready);
	modport sink (input valid, input applicable, input cool_action,
		input shutdown_req, input suspend_req, input poll_event,
		input reset_flag, output ready);
endinterface
`default_nettype wire

// ----- src/ttpe_cfg_if.sv -----
`default_nettype none
interface ttpe_cfg_if
	import ttpe_pkg::*;
#(
	parameter int TEMP_BITS = TEMP_BITS_DEF
);
	localparam int DATA_BITS = (TEMP_BITS > SENSOR_SEL_BITS) ? TEMP_BITS : SENSOR_SEL_BITS;

	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/thermal_trip_point_evaluator.sv -----
// channel  | dir | payload
// ---------+-----+------------------------------------------------------------
// cfg      | in  | index, data (register write)
// reading  | in  | reading_sensor, reading_temp, preference, cooling_state
// result   | out | applicable, cool_action, shutdown_req, suspend_req,
//          |     | poll_event, reset_flag
//
// One item per cycle sustained while the result side is ready; an accepted item
// passes the input register, then the result register. Trip state updates
// as an item moves into the result register. Reset clears control state and
// loads the register reset values. A stalled result holds one item in the
// input stage, then reading.ready drops. cfg.ready is always high.
`default_nettype none
module thermal_trip_point_evaluator
	import ttpe_pkg::*;
#(
	parameter int TEMP_BITS = TEMP_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	ttpe_cfg_if.sink    cfg,
	ttpe_in_if.sink     reading,
	ttpe_out_if.source  result
);

	// configuration
	trip_kind_t                 trip_kind_q;
	logic [TEMP_BITS-1:0]       trip_temp_q;
	logic [TEMP_BITS-1:0]       hysteresis_q;
	logic [SENSOR_SEL_BITS-1:0] sensor_select_q;
	logic [2:0]                 dep_relation_q;
	logic [STATE_BITS-1:0]      dep_value_q;
	logic [COUNT_BITS-1:0]      crit_limit_q;
	logic                       ignore_crit_q;

	// trip state
	logic                  cooling_active_q;
	logic                  polling_active_q;
	logic [COUNT_BITS-1:0] crit_count_q;

	// input stage
	logic                   valid_s1;
	logic [SENSOR_BITS-1:0] sensor_s1;
	logic [TEMP_BITS-1:0]   temp_s1;
	pref_t                  pref_s1;
	logic [STATE_BITS-1:0]  cstate_s1;

	// result register
	logic         out_valid_q;
	logic         applicable_q;
	cool_action_t cool_action_q;
	logic         shutdown_q;
	logic         suspend_q;
	poll_event_t  poll_event_q;
	logic         reset_flag_q;

	logic advance;
	logic accept;

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign reading.ready = !valid_s1 || advance;
	assign accept = reading.valid && reading.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_kind_q     <= KIND_INVALID;
			trip_temp_q     <= '0;
			hysteresis_q    <= '0;
			sensor_select_q <= ANY_SENSOR;
			dep_relation_q  <= REL_NONE;
			dep_value_q     <= '0;
			crit_limit_q    <= '0;
			ignore_crit_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TRIP_KIND:     trip_kind_q     <= trip_kind_t'(cfg.data[2:0]);
				REG_TRIP_TEMP:     trip_temp_q     <= cfg.data[TEMP_BITS-1:0];
				REG_HYSTERESIS:    hysteresis_q    <= cfg.data[TEMP_BITS-1:0];
				REG_SENSOR_SELECT: sensor_select_q <= cfg.data[SENSOR_SEL_BITS-1:0];
				REG_DEP_RELATION:  dep_relation_q  <= cfg.data[2:0];
				REG_DEP_VALUE:     dep_value_q     <= cfg.data[STATE_BITS-1:0];
				REG_CRIT_LIMIT:    crit_limit_q    <= cfg.data[COUNT_BITS-1:0];
				REG_IGNORE_CRIT:   ignore_crit_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// evaluation of the item in the input stage
	logic                  at_or_above;
	logic                  rel_holds;
	logic                  pass;
	logic                  any_sensor;
	logic [TEMP_BITS:0]    temp_plus_hyst;
	logic                  apply;
	logic                  n_applicable;
	cool_action_t          n_cool;
	logic                  n_shutdown;
	logic                  n_suspend;
	poll_event_t           n_poll;
	logic                  n_reset_flag;
	logic                  n_cooling;
	logic                  n_polling;
	logic [COUNT_BITS-1:0] n_count;

	assign at_or_above = temp_s1 >= trip_temp_q;
	assign any_sensor = sensor_select_q == ANY_SENSOR;
	assign temp_plus_hyst = {1'b0, temp_s1} + {1'b0, hysteresis_q};

	always_comb begin
		unique case (dep_rel_t'(dep_relation_q))
			REL_EQ:  rel_holds = cstate_s1 == dep_value_q;
			REL_GT:  rel_holds = cstate_s1 > dep_value_q;
			REL_LT:  rel_holds = cstate_s1 < dep_value_q;
			REL_LE:  rel_holds = cstate_s1 <= dep_value_q;
			REL_GE:  rel_holds = cstate_s1 >= dep_value_q;
			default: rel_holds = 1'b0;
		endcase
	end

	always_comb begin
		pass = (trip_kind_q != KIND_INVALID) && (trip_kind_q <= KIND_MAX)
			&& (dep_relation_q == REL_NONE || !at_or_above || rel_holds)
			&& (any_sensor || sensor_select_q == {1'b0, sensor_s1});

		n_applicable = 1'b0;
		n_cool       = COOL_NONE;
		n_shutdown   = 1'b0;
		n_suspend    = 1'b0;
		n_poll       = POLL_NONE;
		n_reset_flag = 1'b0;
		n_cooling    = cooling_active_q;
		n_polling    = polling_active_q;
		n_count      = crit_count_q;
		apply        = 1'b0;

		if (pass) begin
			case (trip_kind_q) inside
				KIND_CRITICAL, KIND_HOT: begin
					if (!ignore_crit_q && at_or_above) begin
						n_applicable = 1'b1;
						if (crit_count_q < crit_limit_q) begin
							n_count = crit_count_q + 1'b1;
						end else begin
							n_count = '0;
							n_shutdown = trip_kind_q == KIND_CRITICAL;
							n_suspend  = trip_kind_q == KIND_HOT;
						end
					end else begin
						n_count = '0;
					end
				end
				KIND_POLLING: begin
					if (!any_sensor) begin
						n_applicable = 1'b1;
						if (!polling_active_q && at_or_above) begin
							n_polling = 1'b1;
							n_poll    = POLL_START;
						end else if (polling_active_q && !at_or_above) begin
							n_polling    = 1'b0;
							n_poll       = POLL_STOP;
							n_reset_flag = 1'b1;
						end
					end
				end
				default: begin
					case (pref_s1)
						PREF_PERF:   apply = trip_kind_q == KIND_ACTIVE
							|| trip_kind_q == KIND_MAX;
						PREF_ENERGY: apply = trip_kind_q == KIND_PASSIVE
							|| trip_kind_q == KIND_MAX;
						default:     apply = 1'b0;
					endcase
					if (apply) begin
						n_applicable = 1'b1;
						if (at_or_above) begin
							n_cooling = 1'b1;
							n_cool    = COOL_ON;
						end else if (!cooling_active_q
							|| temp_plus_hyst < {1'b0, trip_temp_q}) begin
							n_cooling = 1'b0;
							n_cool    = COOL_OFF;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading.ready) begin
			valid_s1 <= reading.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sensor_s1 <= reading.reading_sensor;
			temp_s1   <= reading.reading_temp;
			pref_s1   <= pref_t'(reading.preference);
			cstate_s1 <= reading.cooling_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_active_q <= 1'b0;
			polling_active_q <= 1'b0;
			crit_count_q     <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (advance) begin
				cooling_active_q <= n_cooling;
				polling_active_q <= n_polling;
				crit_count_q     <= n_count;
				out_valid_q      <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			applicable_q  <= n_applicable;
			cool_action_q <= n_cool;
			shutdown_q    <= n_shutdown;
			suspend_q     <= n_suspend;
			poll_event_q  <= n_poll;
			reset_flag_q  <= n_reset_flag;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.applicable   = applicable_q;
	assign result.cool_action  = cool_action_q;
	assign result.shutdown_req = shutdown_q;
	assign result.suspend_req  = suspend_q;
	assign result.poll_event   = poll_event_q;
	assign result.reset_flag   = reset_flag_q;

`ifndef ASSERT_OFF
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded");

	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !result.ready) |-> !reading.ready)
		else $error("item accepted while both stages stalled");

	a_req_applicable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (shutdown_q || suspend_q)) |-> applicable_q)
		else $error("request on non-applicable item");

	a_reset_flag_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && reset_flag_q) |-> (poll_event_q == POLL_STOP))
		else $error("reset flag without poll stop");

	a_poll_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && n_poll == POLL_START) |=> polling_active_q)
		else $error("polling flag not set on start");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/thermal_trip_point_evaluator_test.sv -----
`timescale 1ns / 1ps
module thermal_trip_point_evaluator_test;
	import ttpe_pkg::*;

	localparam int TW = TEMP_BITS_DEF;
	localparam int CFG_DATA_BITS = (TW > SENSOR_SEL_BITS) ? TW : SENSOR_SEL_BITS;
	localparam int TEMP_MAX = (1 << TW) - 1;
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam logic [2:0] REL_UNUSED = 3'd7;
	localparam int STUCK_LIMIT = 1000;
	localparam int PHASES = 24;
	localparam int PHASE_ITEMS = 77;

	typedef struct packed {
		logic         applicable;
		cool_action_t cool;
		logic         shutdown;
		logic         suspend;
		poll_event_t  poll;
		logic         rst_flag;
	} verdict_t;

	typedef struct packed {
		logic     known;
		verdict_t v;
	} typed_check_t;

	typedef struct packed {
		logic                     is_cfg;
		cfg_reg_t                 reg_idx;
		logic [CFG_DATA_BITS-1:0] reg_data;
		logic [7:0]               sensor;
		logic [TW-1:0]            temp;
		pref_t                    pref;
		logic [7:0]               cstate;
		typed_check_t             check;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ttpe_cfg_if #(.TEMP_BITS(TW)) cfg_bus ();
	ttpe_in_if #(.TEMP_BITS(TW)) rd_bus ();
	ttpe_out_if res_bus ();

	thermal_trip_point_evaluator #(.TEMP_BITS(TW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.reading(rd_bus),
		.result(res_bus)
	);

	// trip point copy
	logic [2:0]                 tp_kind = KIND_INVALID;
	logic [TW-1:0]              tp_temp = '0;
	logic [TW-1:0]              tp_hyst = '0;
	logic [SENSOR_SEL_BITS-1:0] tp_sensor = ANY_SENSOR;
	logic [2:0]                 tp_rel = REL_NONE;
	logic [7:0]                 tp_dep_val = '0;
	logic [7:0]                 tp_crit_limit = '0;
	logic                       tp_ignore = 1'b0;
	logic                       st_cooling = 1'b0;
	logic                       st_polling = 1'b0;
	logic [7:0]                 st_crit_count = '0;

	verdict_t     pending_verdicts[$];
	typed_check_t directed_checks[$];
	stim_row_t    directed_rows[$];

	int errors = 0;
	int stuck = 0;
	int n_readings = 0;
	int n_results = 0;
	int n_writes = 0;
	int n_shutdown = 0;
	int n_suspend = 0;
	int n_poll_start = 0;
	int n_cool_on = 0;
	int n_cool_off = 0;
	int sink_mode = 1;
	int hold_req = 0;
	int holds_seen = 0;
	int hold_cycles = 0;
	int stall_tick = 0;
	logic progress;
	verdict_t predicted;
	verdict_t want;
	typed_check_t chk;

	function automatic logic dep_holds(logic [7:0] cstate);
		case (tp_rel)
			REL_EQ: return cstate == tp_dep_val;
			REL_GT: return cstate > tp_dep_val;
			REL_LT: return cstate < tp_dep_val;
			REL_LE: return cstate <= tp_dep_val;
			REL_GE: return cstate >= tp_dep_val;
			default: return 1'b0;
		endcase
	endfunction

	function automatic verdict_t evaluate_trip(logic [7:0] sensor, logic [TW-1:0] temp,
		logic [1:0] pref, logic [7:0] cstate);
		verdict_t v;
		logic above;
		logic pref_ok;
		v = '0;
		above = temp >= tp_temp;
		if (!(tp_kind inside {KIND_CRITICAL, KIND_HOT, KIND_POLLING, KIND_ACTIVE,
			KIND_PASSIVE, KIND_MAX}))
			return v;
		if (tp_rel != REL_NONE && above && !dep_holds(cstate))
			return v;
		if (tp_sensor != ANY_SENSOR && tp_sensor != {1'b0, sensor})
			return v;
		if (tp_kind == KIND_CRITICAL || tp_kind == KIND_HOT) begin
			if (!tp_ignore && above) begin
				v.applicable = 1'b1;
				if (st_crit_count < tp_crit_limit) begin
					st_crit_count = st_crit_count + 8'd1;
					return v;
				end
				st_crit_count = '0;
				if (tp_kind == KIND_CRITICAL)
					v.shutdown = 1'b1;
				else
					v.suspend = 1'b1;
				return v;
			end
			st_crit_count = '0;
			return v;
		end
		if (tp_kind == KIND_POLLING) begin
			if (tp_sensor == ANY_SENSOR)
				return v;
			if (!st_polling && above) begin
				st_polling = 1'b1;
				v.poll = POLL_START;
			end else if (st_polling && !above) begin
				st_polling = 1'b0;
				v.poll = POLL_STOP;
				v.rst_flag = 1'b1;
			end
			v.applicable = 1'b1;
			return v;
		end
		pref_ok = (pref == PREF_PERF && (tp_kind == KIND_ACTIVE || tp_kind == KIND_MAX))
			|| (pref == PREF_ENERGY && (tp_kind == KIND_PASSIVE || tp_kind == KIND_MAX));
		if (!pref_ok)
			return v;
		v.applicable = 1'b1;
		if (above) begin
			st_cooling = 1'b1;
			v.cool = COOL_ON;
		end else if (!st_cooling || ({1'b0, temp} + {1'b0, tp_hyst}) < {1'b0, tp_temp}) begin
			st_cooling = 1'b0;
			v.cool = COOL_OFF;
		end
		return v;
	endfunction

	function automatic void check_field(string name, logic [1:0] exp_val, logic [1:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endfunction

	function automatic verdict_t make_verdict(logic app, cool_action_t c, logic sd, logic sp,
		poll_event_t pe, logic rf);
		verdict_t v;
		v.applicable = app;
		v.cool = c;
		v.shutdown = sd;
		v.suspend = sp;
		v.poll = pe;
		v.rst_flag = rf;
		return v;
	endfunction

	function automatic void cfg_row(cfg_reg_t idx, int unsigned value);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_data = CFG_DATA_BITS'(value);
		directed_rows.push_back(r);
	endfunction

	function automatic void rd_row(logic [7:0] s, int unsigned t, pref_t pf, logic [7:0] c,
		logic known, verdict_t v);
		stim_row_t r;
		r = '0;
		r.sensor = s;
		r.temp = TW'(t);
		r.pref = pf;
		r.cstate = c;
		r.check.known = known;
		r.check.v = v;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [TW-1:0] pick_temp(logic bias_hi);
		int t;
		int base;
		int hyst;
		base = int'(tp_temp);
		hyst = int'(tp_hyst);
		if (bias_hi && $urandom_range(0, 9) < 7)
			t = base + int'($urandom_range(0, 5));
		else begin
			case ($urandom_range(0, 9)) inside
				0: t = 0;
				1: t = TEMP_MAX;
				2, 3, 4: t = base + int'($urandom_range(0, 6)) - 3;
				5, 6: t = base - hyst + int'($urandom_range(0, 4)) - 2;
				default: t = int'($urandom_range(0, TEMP_MAX));
			endcase
		end
		if (t < 0)
			t = 0;
		if (t > TEMP_MAX)
			t = TEMP_MAX;
		return TW'(t);
	endfunction

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		logic [CFG_DATA_BITS-1:0] mask;
		logic [CFG_DATA_BITS-1:0] junk;
		int w;
		case (idx) inside
			REG_TRIP_KIND, REG_DEP_RELATION: w = 3;
			REG_TRIP_TEMP, REG_HYSTERESIS: w = TW;
			REG_SENSOR_SELECT: w = SENSOR_SEL_BITS;
			REG_DEP_VALUE, REG_CRIT_LIMIT: w = 8;
			default: w = 1;
		endcase
		mask = '1;
		mask = ~(mask << w);
		junk = $urandom_range(0, 1) ? CFG_DATA_BITS'($urandom()) : '0;
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= (junk & ~mask) | (CFG_DATA_BITS'(value) & mask);
		do
			@(posedge clk);
		while (!cfg_bus.ready);
	endtask

	task automatic send_reading(logic [7:0] s, logic [TW-1:0] t, pref_t pf, logic [7:0] c);
		rd_bus.valid <= 1'b1;
		rd_bus.reading_sensor <= s;
		rd_bus.reading_temp <= t;
		rd_bus.preference <= pf;
		rd_bus.cooling_state <= c;
		do
			@(posedge clk);
		while (!rd_bus.ready);
	endtask

	// stop offering and wait for every result to come back
	task automatic settle();
		rd_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_verdicts.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: own stall pattern, plus long hold-offs on request
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				hold_cycles--;
				res_bus.ready <= 1'b0;
			end else if (holds_seen != hold_req) begin
				holds_seen = hold_req;
				hold_cycles = 90;
				res_bus.ready <= 1'b0;
			end else begin
				stall_tick++;
				case (sink_mode)
					0: res_bus.ready <= 1'b1;
					1: res_bus.ready <= ($urandom_range(0, 9) < 7);
					default: res_bus.ready <= (stall_tick % 11) >= 4;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_TRIP_KIND: tp_kind = cfg_bus.data[2:0];
					REG_TRIP_TEMP: tp_temp = cfg_bus.data[TW-1:0];
					REG_HYSTERESIS: tp_hyst = cfg_bus.data[TW-1:0];
					REG_SENSOR_SELECT: tp_sensor = cfg_bus.data[SENSOR_SEL_BITS-1:0];
					REG_DEP_RELATION: tp_rel = cfg_bus.data[2:0];
					REG_DEP_VALUE: tp_dep_val = cfg_bus.data[7:0];
					REG_CRIT_LIMIT: tp_crit_limit = cfg_bus.data[7:0];
					REG_IGNORE_CRIT: tp_ignore = cfg_bus.data[0];
					default: ;
				endcase
				n_writes++;
				progress = 1'b1;
			end
			if (rd_bus.valid && rd_bus.ready) begin
				predicted = evaluate_trip(rd_bus.reading_sensor, rd_bus.reading_temp,
					rd_bus.preference, rd_bus.cooling_state);
				if (directed_checks.size() != 0) begin
					chk = directed_checks.pop_front();
					if (chk.known)
						predicted = chk.v;
				end
				pending_verdicts.push_back(predicted);
				n_readings++;
				progress = 1'b1;
			end
			if (res_bus.valid && res_bus.ready) begin
				progress = 1'b1;
				n_results++;
				if (pending_verdicts.size() == 0) begin
					$display("%0t: result with nothing outstanding", $time);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					check_field("applicable", {1'b0, want.applicable},
						{1'b0, res_bus.applicable});
					check_field("cool_action", want.cool, res_bus.cool_action);
					check_field("shutdown_req", {1'b0, want.shutdown},
						{1'b0, res_bus.shutdown_req});
					check_field("suspend_req", {1'b0, want.suspend},
						{1'b0, res_bus.suspend_req});
					check_field("poll_event", want.poll, res_bus.poll_event);
					check_field("reset_flag", {1'b0, want.rst_flag},
						{1'b0, res_bus.reset_flag});
				end
				n_shutdown += int'(res_bus.shutdown_req);
				n_suspend += int'(res_bus.suspend_req);
				n_poll_start += int'(res_bus.poll_event == POLL_START);
				n_cool_on += int'(res_bus.cool_action == COOL_ON);
				n_cool_off += int'(res_bus.cool_action == COOL_OFF);
			end
			if (progress)
				stuck = 0;
			else begin
				stuck++;
				if (stuck >= STUCK_LIMIT) begin
					$display("%0t: no progress for %0d cycles, %0d results outstanding",
						$time, stuck, pending_verdicts.size());
					$display("[thermal_trip_point_evaluator] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		int p;
		int k;
		int burst_left;
		int gap;
		logic bursty;
		logic bias_hi;
		logic cfg_open;
		logic [7:0] s;
		logic [7:0] c;
		int ci;
		stim_row_t row;
		verdict_t zero;

		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		rd_bus.valid = 1'b0;
		rd_bus.reading_sensor = '0;
		rd_bus.reading_temp = '0;
		rd_bus.preference = '0;
		rd_bus.cooling_state = '0;
		zero = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rd_row(8'd0, 0, PREF_OFF, 8'd0, 1'b1, zero);
		rd_row(8'd255, TEMP_MAX, PREF_OTHER, 8'd255, 1'b1, zero);
		cfg_row(REG_TRIP_KIND, KIND_CRITICAL);
		cfg_row(REG_TRIP_TEMP, 1000);
		rd_row(8'd5, 1000, PREF_PERF, 8'd0, 1'b1,
			make_verdict(1'b1, COOL_NONE, 1'b1, 1'b0, POLL_NONE, 1'b0));
		rd_row(8'd5, 999, PREF_PERF, 8'd0, 1'b1, zero);
		cfg_row(REG_TRIP_KIND, KIND_HOT);
		cfg_row(REG_CRIT_LIMIT, 2);
		repeat (3) rd_row(8'd7, TEMP_MAX, PREF_ENERGY, 8'd3, 1'b0, zero);
		cfg_row(REG_IGNORE_CRIT, 1);
		rd_row(8'd7, TEMP_MAX, PREF_ENERGY, 8'd3, 1'b1, zero);
		cfg_row(REG_IGNORE_CRIT, 0);
		cfg_row(REG_TRIP_KIND, KIND_POLLING);
		rd_row(8'd9, 2000, PREF_OTHER, 8'd0, 1'b1, zero);
		cfg_row(REG_SENSOR_SELECT, 9);
		rd_row(8'd9, 2000, PREF_OTHER, 8'd0, 1'b0, zero);
		rd_row(8'd8, 10, PREF_OTHER, 8'd0, 1'b0, zero);
		rd_row(8'd9, 10, PREF_OFF, 8'd0, 1'b0, zero);
		cfg_row(REG_SENSOR_SELECT, 300);
		rd_row(8'd44, 2000, PREF_PERF, 8'd0, 1'b1, zero);
		cfg_row(REG_SENSOR_SELECT, ANY_SENSOR);
		cfg_row(REG_TRIP_KIND, KIND_ACTIVE);
		cfg_row(REG_TRIP_TEMP, TEMP_MAX);
		cfg_row(REG_HYSTERESIS, TEMP_MAX);
		rd_row(8'd1, TEMP_MAX, PREF_PERF, 8'd0, 1'b0, zero);
		rd_row(8'd2, 0, PREF_PERF, 8'd0, 1'b0, zero);
		rd_row(8'd3, 0, PREF_ENERGY, 8'd0, 1'b0, zero);
		// temp + hysteresis must not wrap
		cfg_row(REG_TRIP_TEMP, 100);
		rd_row(8'd4, 50, PREF_PERF, 8'd0, 1'b0, zero);
		cfg_row(REG_TRIP_KIND, KIND_MAX);
		cfg_row(REG_HYSTERESIS, 0);
		rd_row(8'd5, 50, PREF_ENERGY, 8'd0, 1'b0, zero);
		rd_row(8'd6, 100, PREF_OTHER, 8'd0, 1'b0, zero);
		cfg_row(REG_TRIP_KIND, KIND_PASSIVE);
		cfg_row(REG_DEP_RELATION, REL_EQ);
		cfg_row(REG_DEP_VALUE, 255);
		rd_row(8'd7, 200, PREF_ENERGY, 8'd254, 1'b1, zero);
		rd_row(8'd7, 200, PREF_ENERGY, 8'd255, 1'b0, zero);
		rd_row(8'd7, 0, PREF_ENERGY, 8'd0, 1'b0, zero);
		cfg_row(REG_DEP_RELATION, REL_UNUSED);
		rd_row(8'd7, 200, PREF_ENERGY, 8'd0, 1'b1, zero);
		cfg_row(REG_TRIP_KIND, KIND_UNUSED);
		rd_row(8'd7, 200, PREF_ENERGY, 8'd0, 1'b1, zero);

		cfg_open = 1'b0;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				if (!cfg_open)
					settle();
				write_reg(row.reg_idx, row.reg_data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_bus.valid <= 1'b0;
					cfg_open = 1'b0;
				end
				directed_checks.push_back(row.check);
				send_reading(row.sensor, row.temp, row.pref, row.cstate);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			settle();
			if (p == 5)
				write_reg(REG_TRIP_KIND, KIND_INVALID);
			else if (p == 17)
				write_reg(REG_TRIP_KIND, KIND_UNUSED);
			else
				write_reg(REG_TRIP_KIND, (p % 6) + 1);
			case (p % 8)
				0: write_reg(REG_TRIP_TEMP, 0);
				1: write_reg(REG_TRIP_TEMP, TEMP_MAX);
				default: write_reg(REG_TRIP_TEMP, $urandom_range(0, TEMP_MAX));
			endcase
			case (p % 5)
				0: write_reg(REG_HYSTERESIS, 0);
				1: write_reg(REG_HYSTERESIS, TEMP_MAX);
				2: write_reg(REG_HYSTERESIS, $urandom_range(0, 20));
				default: write_reg(REG_HYSTERESIS, $urandom_range(0, TEMP_MAX));
			endcase
			if (p % 12 == 1)
				write_reg(REG_SENSOR_SELECT, $urandom_range(ANY_SENSOR + 1, 511));
			else if (p % 4 == 0)
				write_reg(REG_SENSOR_SELECT, ANY_SENSOR);
			else
				write_reg(REG_SENSOR_SELECT, $urandom_range(0, 255));
			if (p % 11 == 7)
				write_reg(REG_DEP_RELATION, REL_UNUSED - $urandom_range(0, 1));
			else if (p % 3 == 0)
				write_reg(REG_DEP_RELATION, REL_NONE);
			else
				write_reg(REG_DEP_RELATION, $urandom_range(REL_EQ, REL_GE));
			case (p % 7)
				0: write_reg(REG_DEP_VALUE, 0);
				1: write_reg(REG_DEP_VALUE, 255);
				default: write_reg(REG_DEP_VALUE, $urandom_range(0, 255));
			endcase
			if (p % 9 == 4)
				write_reg(REG_CRIT_LIMIT, 255);
			else if (p % 6 == 0)
				write_reg(REG_CRIT_LIMIT, 0);
			else
				write_reg(REG_CRIT_LIMIT, $urandom_range(0, 4));
			write_reg(REG_IGNORE_CRIT, (p % 5 == 3) ? 1 : 0);
			cfg_bus.valid <= 1'b0;

			sink_mode <= $urandom_range(0, 2);
			bias_hi = 1'($urandom_range(0, 1));
			bursty = (p % 6 != 2) && ($urandom_range(0, 3) != 0);
			// stall the result side long enough to back up the input
			if (p % 6 == 2)
				hold_req <= hold_req + 1;
			burst_left = $urandom_range(1, 24);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (bursty && burst_left == 0) begin
					gap = $urandom_range(1, 8);
					rd_bus.valid <= 1'b0;
					repeat (gap) @(posedge clk);
					burst_left = $urandom_range(1, 24);
				end
				if (tp_sensor < ANY_SENSOR && $urandom_range(0, 3) != 0)
					s = tp_sensor[7:0];
				else
					s = 8'($urandom_range(0, 255));
				if (tp_rel != REL_NONE && $urandom_range(0, 1)) begin
					ci = int'(tp_dep_val) + int'($urandom_range(0, 2)) - 1;
					if (ci < 0)
						ci = 0;
					if (ci > 255)
						ci = 255;
					c = ci[7:0];
				end else begin
					case ($urandom_range(0, 7))
						0: c = 8'd0;
						1: c = 8'd255;
						default: c = 8'($urandom_range(0, 255));
					endcase
				end
				send_reading(s, pick_temp(bias_hi), pref_t'($urandom_range(0, 3)), c);
				if (burst_left != 0)
					burst_left--;
			end
		end
		settle();
		repeat (5) @(posedge clk);

		$display("covered %0d readings, %0d results, %0d register writes, %0d settings",
			n_readings, n_results, n_writes, PHASES);
		$display("shutdown %0d, suspend %0d, poll start %0d, cooling on %0d, off %0d",
			n_shutdown, n_suspend, n_poll_start, n_cool_on, n_cool_off);
		if (errors == 0)
			$display("[thermal_trip_point_evaluator] OK");
		else
			$display("[thermal_trip_point_evaluator] ERROR");
		$finish;
	end

endmodule
